// ===== hdl/pgw_pkg.sv =====
// shared types and constants for the four-level page table walker
// no dependencies; imported by pgw_store and the top level
package pgw_pkg;

    localparam int POOL_FRAMES       = 64;
    localparam int ENTRIES_PER_TABLE = 512;

    localparam int FRAME_W = 40;
    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int IDX_W   = $clog2(ENTRIES_PER_TABLE);
    localparam int SLOT_W  = $clog2(POOL_FRAMES);
    localparam int NFS_W   = $clog2(POOL_FRAMES + 1);
    localparam int ADDR_W  = SLOT_W + IDX_W;
    localparam int DEPTH   = POOL_FRAMES * ENTRIES_PER_TABLE;
    localparam int PAGE_SHIFT = 12;

    localparam logic [FRAME_W-1:0] RESET_BASE_FRAME = FRAME_W'(512);

    localparam logic [1:0] ACT_FAULT  = 2'd0;
    localparam logic [1:0] ACT_MAP    = 2'd1;
    localparam logic [1:0] ACT_UNMAP  = 2'd2;
    localparam logic [1:0] ACT_LOOKUP = 2'd3;

    typedef struct packed {
        logic [1:0]      action;
        logic [VA_W-1:0] virtual_address;
        logic [PA_W-1:0] physical_address;
    } t_pgw_req;

    typedef struct packed {
        logic               status;
        logic [FRAME_W-1:0] leaf_frame;
        logic               leaf_was_present;
        logic [2:0]         frames_allocated;
    } t_pgw_rsp;

    typedef struct packed {
        logic               present;
        logic [FRAME_W-1:0] frame;
    } t_pgw_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_pgw_rd;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_pgw_entry        data;
    } t_pgw_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_pgw_state;

endpackage

// ===== hdl/four_level_page_table_walker_unit.sv =====
// four-level page table walker: request sequencer around the table store
// depends on pgw_pkg and pgw_store
//
// usage:
//   requests enter on i_in_valid / o_in_ready with a t_pgw_req payload
//   (action, virtual address, physical address); one result per request
//   leaves on o_out_valid / i_out_ready as a t_pgw_rsp payload.
//   i_cfg_we / i_cfg_wdata write the pool base frame; write it only while idle.
// timing:
//   each request walks four levels, one read and one check state per level,
//   then the done state loads the result register; fewer levels when the
//   walk stops early. the next request is taken the cycle after the result
//   loads; one request at a time, bounded by the single read port of the store.
// reset:
//   the table store is swept to not present, one entry a cycle, all 32768 entries;
//   o_in_ready stays low until the sweep is over. pool base returns to 512,
//   the allocator to slot one.
// stall:
//   a finished result waits in the output register; a new request is still
//   taken, and its result is held back until the old one is taken.
module four_level_page_table_walker_unit import pgw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_pgw_req           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_pgw_rsp           o_out_data,
    input  logic               i_cfg_we,
    input  logic [FRAME_W-1:0] i_cfg_wdata
);

    t_pgw_state r_state, n_state;
    t_pgw_req   r_req;
    logic [FRAME_W-1:0] r_pool_base;
    logic [NFS_W-1:0]   r_next_free, n_next_free;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [1:0]         r_level, n_level;
    logic               r_status, n_status;
    logic [FRAME_W-1:0] r_leaf, n_leaf;
    logic               r_was, n_was;
    logic [2:0]         r_taken, n_taken;
    logic               r_out_valid, n_out_valid;
    t_pgw_rsp           r_out_data, n_out_data;

    t_pgw_rd    w_rd;
    t_pgw_wr    w_wr;
    t_pgw_entry w_entry;
    logic       w_clr_busy;
    logic       w_stop;
    logic       w_accept;
    logic       w_out_free;
    logic [IDX_W-1:0]   w_idx;
    logic [FRAME_W-1:0] w_slot_diff;
    logic               w_slot_ok;
    logic               w_pool_empty;
    logic [FRAME_W-1:0] w_new_frame;

    pgw_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (w_rd),
        .i_wr       (w_wr),
        .o_rd_data  (w_entry),
        .o_clr_busy (w_clr_busy)
    );

    assign o_in_ready  = (r_state == ST_IDLE) && !w_clr_busy;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        unique case (r_level)
            2'd0:    w_idx = r_req.virtual_address[47:39];
            2'd1:    w_idx = r_req.virtual_address[38:30];
            2'd2:    w_idx = r_req.virtual_address[29:21];
            default: w_idx = r_req.virtual_address[20:12];
        endcase
    end

    assign w_slot_diff  = w_entry.frame - r_pool_base;
    assign w_slot_ok    = w_slot_diff < FRAME_W'(POOL_FRAMES);
    assign w_pool_empty = r_next_free >= NFS_W'(POOL_FRAMES);
    assign w_new_frame  = r_pool_base + FRAME_W'(r_next_free);

    // walk step: decides the table read and write, what carries to the next level and the result load
    always_comb begin
        n_slot      = r_slot;
        n_level     = r_level;
        n_next_free = r_next_free;
        n_status    = r_status;
        n_leaf      = r_leaf;
        n_was       = r_was;
        n_taken     = r_taken;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_stop      = 1'b0;
        w_rd.en     = 1'b0;
        w_rd.addr   = {r_slot, w_idx};
        w_wr.en     = 1'b0;
        w_wr.addr   = {r_slot, w_idx};
        w_wr.data   = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_slot   = '0;
                    n_level  = 2'd0;
                    n_status = 1'b0;
                    n_leaf   = '0;
                    n_was    = 1'b0;
                    n_taken  = '0;
                end
            end
            ST_READ: begin
                w_rd.en = 1'b1;
            end
            ST_CHECK: begin
                if (r_level != 2'd3) begin
                    if (w_entry.present) begin
                        if (w_slot_ok) begin
                            n_slot  = w_slot_diff[SLOT_W-1:0];
                            n_level = r_level + 2'd1;
                        end else begin
                            n_status = 1'b1;
                            w_stop   = 1'b1;
                        end
                    end else if (r_req.action == ACT_UNMAP || r_req.action == ACT_LOOKUP) begin
                        w_stop = 1'b1;
                    end else if (w_pool_empty) begin
                        n_status = 1'b1;
                        w_stop   = 1'b1;
                    end else begin
                        w_wr.en           = 1'b1;
                        w_wr.data.present = 1'b1;
                        w_wr.data.frame   = w_new_frame;
                        n_taken     = r_taken + 3'd1;
                        n_slot      = r_next_free[SLOT_W-1:0];
                        n_next_free = r_next_free + NFS_W'(1);
                        n_level     = r_level + 2'd1;
                    end
                end else begin
                    // leaf level
                    w_stop = 1'b1;
                    n_was  = w_entry.present;
                    n_leaf = w_entry.present ? w_entry.frame : '0;
                    unique case (r_req.action)
                        ACT_FAULT: begin
                            if (!w_entry.present) begin
                                if (w_pool_empty) begin
                                    n_status = 1'b1;
                                end else begin
                                    w_wr.en           = 1'b1;
                                    w_wr.data.present = 1'b1;
                                    w_wr.data.frame   = w_new_frame;
                                    n_leaf      = w_new_frame;
                                    n_taken     = r_taken + 3'd1;
                                    n_next_free = r_next_free + NFS_W'(1);
                                end
                            end
                        end
                        ACT_MAP: begin
                            if (!w_entry.present) begin
                                w_wr.en           = 1'b1;
                                w_wr.data.present = 1'b1;
                                w_wr.data.frame   =
                                    r_req.physical_address[PA_W-1:PAGE_SHIFT];
                                n_leaf = r_req.physical_address[PA_W-1:PAGE_SHIFT];
                            end
                        end
                        ACT_UNMAP: begin
                            n_leaf = '0;
                            if (w_entry.present) begin
                                w_wr.en = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid                 = 1'b1;
                    n_out_data.status           = r_status;
                    n_out_data.leaf_frame       = r_leaf;
                    n_out_data.leaf_was_present = r_was;
                    n_out_data.frames_allocated = r_taken;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_READ;
            ST_READ:  n_state = ST_CHECK;
            ST_CHECK: n_state = w_stop ? ST_DONE : ST_READ;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pool_base <= RESET_BASE_FRAME;
            r_next_free <= NFS_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_pool_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
        r_slot     <= n_slot;
        r_level    <= n_level;
        r_status   <= n_status;
        r_leaf     <= n_leaf;
        r_was      <= n_was;
        r_taken    <= n_taken;
        r_out_data <= n_out_data;
    end

endmodule

// ===== hdl/pgw_store.sv =====
// table store: one synchronous ram holding all page table entries
// sweeps every entry to not present after reset; uses pgw_pkg
module pgw_store import pgw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pgw_rd    i_rd,
    input  t_pgw_wr    i_wr,
    output t_pgw_entry o_rd_data,
    output logic       o_clr_busy
);

    t_pgw_entry r_mem [DEPTH];
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] n_clr_addr;
    logic              n_clr_busy;
    t_pgw_entry        r_rd_data;

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_clr_busy = r_clr_busy;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == {ADDR_W{1'b1}}) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_busy <= 1'b1;
        end else begin
            r_clr_addr <= n_clr_addr;
            r_clr_busy <= n_clr_busy;
        end
    end

    // clearing sweep owns the write port until it finishes
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for four_level_page_table_walker_unit
// depends on pgw_pkg and the walker rtl; predicts each response from its own page table copy unless a row pins it
`timescale 1ns / 1ps

module tb import pgw_pkg::*; ();

    localparam logic RSP_OK      = 1'b0;
    localparam logic RSP_STOPPED = 1'b1;

    localparam logic [FRAME_W-1:0] WRAP_BASE = 40'hFF_FFFF_FFF6;
    localparam logic [VA_W-1:0]    TOP_STEP  = VA_W'(1) << (PAGE_SHIFT + 3 * IDX_W);
    localparam logic [VA_W-1:0]    PAGE_STEP = VA_W'(1) << PAGE_SHIFT;
    localparam logic [VA_W-1:0]    VA_MAX    = '1;
    localparam logic [PA_W-1:0]    PA_MAX    = '1;

    localparam int PHASES        = 5;
    localparam int PER_PHASE     = 110;
    localparam int PAUSE_AT      = 60;
    localparam int SEND_QUIET_LO = 220;
    localparam int SEND_QUIET_HI = 320;
    localparam int RECV_QUIET_LO = 250;
    localparam int RECV_QUIET_HI = 350;
    localparam int STALL_AT      = 120;
    localparam int STALL_CYCLES  = 300;
    localparam int END_TAIL      = 20;
    localparam int WATCHDOG_MAX  = 150000;

    // pool base per random phase, entry 0 keeps the reset value
    localparam logic [PHASES-1:0][FRAME_W-1:0] PHASE_BASE = {
        RESET_BASE_FRAME, WRAP_BASE, {FRAME_W{1'b1}}, {FRAME_W{1'b0}}, RESET_BASE_FRAME
    };

    typedef enum bit {ROW_REQ, ROW_BASE} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [FRAME_W-1:0] base;
        t_pgw_req           req;
        int                 reps;
        bit                 pinned;
        t_pgw_rsp           rsp;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_pgw_req           i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    t_pgw_rsp           o_out_data;
    logic               i_cfg_we;
    logic [FRAME_W-1:0] i_cfg_wdata;

    // typed expectation travelling with the request currently offered
    bit       pin_on;
    t_pgw_rsp pin_rsp;

    // page table copy and allocator of the predictor
    t_pgw_entry         table_mem [DEPTH] = '{default: '0};
    int unsigned        alloc_next = 1;
    logic [FRAME_W-1:0] pool_base = RESET_BASE_FRAME;

    t_pgw_rsp expected_q [$];
    int       items_sent   = 0;
    int       results_seen = 0;
    int       fail_count   = 0;
    int       stuck_cycles = 0;

    four_level_page_table_walker_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic int unsigned tbl_pos(int unsigned slot, logic [VA_W-1:0] va, int lv);
        logic [VA_W-1:0] sh;
        sh = va >> (PAGE_SHIFT + IDX_W * (3 - lv));
        return slot * ENTRIES_PER_TABLE + int'(sh[IDX_W-1:0]);
    endfunction

    // one page walk on the local table copy, returns the response it should give
    function automatic t_pgw_rsp walk_request(t_pgw_req r);
        t_pgw_rsp           rsp;
        t_pgw_entry         ent;
        logic [FRAME_W-1:0] rel;
        int unsigned        slot;
        int unsigned        pos;
        rsp  = '0;
        slot = 0;
        for (int lv = 0; lv < 3; lv++) begin
            pos = tbl_pos(slot, r.virtual_address, lv);
            ent = table_mem[pos];
            if (ent.present) begin
                rel = ent.frame - pool_base;
                if (rel >= POOL_FRAMES) begin
                    // pointer outside the pool
                    rsp.status = RSP_STOPPED;
                    return rsp;
                end
                slot = int'(rel);
            end else if (r.action == ACT_UNMAP || r.action == ACT_LOOKUP) begin
                return rsp;
            end else if (alloc_next >= POOL_FRAMES) begin
                rsp.status = RSP_STOPPED;
                return rsp;
            end else begin
                table_mem[pos] = '{present: 1'b1, frame: pool_base + FRAME_W'(alloc_next)};
                slot = alloc_next;
                alloc_next++;
                rsp.frames_allocated += 3'd1;
            end
        end
        pos = tbl_pos(slot, r.virtual_address, 3);
        ent = table_mem[pos];
        rsp.leaf_was_present = ent.present;
        case (r.action)
            ACT_FAULT: begin
                if (!ent.present) begin
                    if (alloc_next >= POOL_FRAMES) begin
                        rsp.status = RSP_STOPPED;
                        return rsp;
                    end
                    table_mem[pos] = '{present: 1'b1, frame: pool_base + FRAME_W'(alloc_next)};
                    alloc_next++;
                    rsp.frames_allocated += 3'd1;
                end
            end
            ACT_MAP: begin
                if (!ent.present)
                    table_mem[pos] = '{present: 1'b1,
                                       frame: r.physical_address[PA_W-1:PAGE_SHIFT]};
            end
            ACT_UNMAP: begin
                if (ent.present)
                    table_mem[pos] = '0;
            end
            default: ;
        endcase
        ent = table_mem[pos];
        rsp.leaf_frame = ent.present ? ent.frame : '0;
        return rsp;
    endfunction

    task automatic check_field(string name, logic [FRAME_W-1:0] want, logic [FRAME_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_pgw_rsp want;
        if (i_rst_n) begin
            if (i_cfg_we)
                pool_base = i_cfg_wdata;
            if (i_in_valid && o_in_ready) begin
                // the predictor always runs so its tables stay in step
                want = walk_request(i_in_data);
                if (pin_on)
                    want = pin_rsp;
                expected_q.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual %h",
                             $time, o_out_data);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", FRAME_W'(want.status), FRAME_W'(o_out_data.status));
                    check_field("leaf_frame", want.leaf_frame, o_out_data.leaf_frame);
                    check_field("leaf_was_present", FRAME_W'(want.leaf_was_present),
                                FRAME_W'(o_out_data.leaf_was_present));
                    check_field("frames_allocated", FRAME_W'(want.frames_allocated),
                                FRAME_W'(o_out_data.frames_allocated));
                end
            end
        end
    end

    // the reset sweep alone keeps both channels quiet for its whole length
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_MAX) begin
                $display("FAIL four_level_page_table_walker_unit");
                $finish;
            end
        end
    end

    initial begin : rx_side
        bit stall_done;
        stall_done = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!stall_done && results_seen >= STALL_AT) begin
                // long hold so the result register and the input both back up
                stall_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= (results_seen >= RECV_QUIET_LO && results_seen < RECV_QUIET_HI) ||
                           ($urandom_range(0, 99) >= 15);
        end
    end

    task automatic send_req(t_pgw_req req, bit pinned, t_pgw_rsp pin);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        pin_on     <= pinned;
        pin_rsp    <= pin;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic idle_gap(bit quiet);
        if (!quiet && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge i_clk);
    endtask

    task automatic write_pool_base(logic [FRAME_W-1:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_dir_row mk_req(logic [1:0] act, logic [VA_W-1:0] va,
                                        logic [PA_W-1:0] pa, int reps);
        t_dir_row row;
        row = '{kind: ROW_REQ, base: '0, req: '{act, va, pa}, reps: reps, pinned: 1'b0,
                rsp: '0};
        return row;
    endfunction

    function automatic t_dir_row mk_pinned(logic [1:0] act, logic [VA_W-1:0] va,
                                           logic [PA_W-1:0] pa, logic st,
                                           logic [FRAME_W-1:0] leaf, logic was,
                                           logic [2:0] taken);
        t_dir_row row;
        row = '{kind: ROW_REQ, base: '0, req: '{act, va, pa}, reps: 1, pinned: 1'b1,
                rsp: '{st, leaf, was, taken}};
        return row;
    endfunction

    function automatic t_dir_row mk_base(logic [FRAME_W-1:0] v);
        t_dir_row row;
        row = '{kind: ROW_BASE, base: v, req: '0, reps: 0, pinned: 1'b0, rsp: '0};
        return row;
    endfunction

    initial begin : tx_side
        t_dir_row        dir_q [$];
        t_pgw_req        rq;
        logic [8:0]      top;
        logic [17:0]     mid;
        logic [8:0]      leaf_idx;
        int              n;

        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        pin_on      <= 1'b0;
        pin_rsp     <= '0;

        // fresh tables at base 512: fault builds three tables and a leaf
        dir_q.push_back(mk_pinned(ACT_FAULT, '0, '0, RSP_OK, FRAME_W'(516), 1'b0, 3'd4));
        dir_q.push_back(mk_pinned(ACT_LOOKUP, '0, '0, RSP_OK, FRAME_W'(516), 1'b1, 3'd0));
        dir_q.push_back(mk_pinned(ACT_UNMAP, '0, '0, RSP_OK, '0, 1'b1, 3'd0));
        dir_q.push_back(mk_pinned(ACT_UNMAP, '0, '0, RSP_OK, '0, 1'b0, 3'd0));
        dir_q.push_back(mk_pinned(ACT_MAP, '0, PA_MAX, RSP_OK, '1, 1'b0, 3'd0));
        // map over a present leaf keeps the old frame
        dir_q.push_back(mk_pinned(ACT_MAP, '0, '0, RSP_OK, '1, 1'b1, 3'd0));
        // unmap and lookup through a missing table
        dir_q.push_back(mk_pinned(ACT_UNMAP, VA_MAX, '0, RSP_OK, '0, 1'b0, 3'd0));
        dir_q.push_back(mk_pinned(ACT_LOOKUP, VA_MAX, '0, RSP_OK, '0, 1'b0, 3'd0));
        dir_q.push_back(mk_pinned(ACT_MAP, VA_MAX, PA_W'(52'h1FFF), RSP_OK, FRAME_W'(1), 1'b0,
                                  3'd3));
        dir_q.push_back(mk_pinned(ACT_FAULT, PAGE_STEP, '0, RSP_OK, FRAME_W'(520), 1'b0, 3'd1));
        // base just below 2^40 so the next walk's frames wrap through zero
        dir_q.push_back(mk_base(WRAP_BASE));
        dir_q.push_back(mk_req(ACT_FAULT, TOP_STEP, '0, 1));
        // old root pointers now fall outside the pool
        dir_q.push_back(mk_pinned(ACT_FAULT, '0, '0, RSP_STOPPED, '0, 1'b0, 3'd0));
        // use up the pool, four frames per new top index
        dir_q.push_back(mk_req(ACT_FAULT, TOP_STEP * 2, '0, 12));
        dir_q.push_back(mk_pinned(ACT_FAULT, TOP_STEP * 14, '0, RSP_STOPPED, '0, 1'b0, 3'd3));
        dir_q.push_back(mk_pinned(ACT_MAP, TOP_STEP * 15, PA_W'(52'hA_BCDE_F012_3456),
                                  RSP_STOPPED, '0, 1'b0, 3'd0));
        dir_q.push_back(mk_pinned(ACT_LOOKUP, TOP_STEP * 14, '0, RSP_OK, '0, 1'b0, 3'd0));
        dir_q.push_back(mk_req(ACT_FAULT, TOP_STEP | VA_W'(12'hFFF), '0, 1));
        dir_q.push_back(mk_base(RESET_BASE_FRAME));
        dir_q.push_back(mk_pinned(ACT_LOOKUP, '0, '0, RSP_OK, '1, 1'b1, 3'd0));

        do @(posedge i_clk); while (!i_rst_n);

        foreach (dir_q[i]) begin
            if (dir_q[i].kind == ROW_BASE) begin
                write_pool_base(dir_q[i].base);
            end else begin
                for (int r = 0; r < dir_q[i].reps; r++) begin
                    rq = dir_q[i].req;
                    rq.virtual_address += VA_W'(r) * TOP_STEP;
                    send_req(rq, dir_q[i].pinned, dir_q[i].rsp);
                    idle_gap(1'b0);
                end
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0)
                write_pool_base(PHASE_BASE[ph]);
            for (int k = 0; k < PER_PHASE; k++) begin
                n = ph * PER_PHASE + k;
                if (n == PAUSE_AT)
                    wait_idle();
                rq.action           = 2'($urandom_range(ACT_FAULT, ACT_LOOKUP));
                rq.physical_address = PA_W'({$urandom, $urandom});
                if ($urandom_range(0, 9) < 2) begin
                    rq.virtual_address = VA_W'({$urandom, $urandom});
                end else begin
                    // mostly prefixes whose tables already exist, top 15 never does
                    top      = ($urandom_range(0, 16) == 16) ? '1 : 9'($urandom_range(0, 15));
                    mid      = (top == '1) ? '1 : '0;
                    leaf_idx = ($urandom_range(0, 3) == 0) ? 9'($urandom)
                                                           : 9'($urandom_range(0, 7));
                    rq.virtual_address = {top, mid, leaf_idx, 12'($urandom)};
                end
                send_req(rq, 1'b0, '0);
                idle_gap(n >= SEND_QUIET_LO && n < SEND_QUIET_HI);
            end
        end

        wait_idle();
        repeat (END_TAIL) @(posedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("PASS four_level_page_table_walker_unit");
        else
            $display("FAIL four_level_page_table_walker_unit");
        $finish;
    end

endmodule
